// ----- src/tail_drop_packet_fifo_core_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the tail-drop packet FIFO
// Shared property forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef TAIL_DROP_PACKET_FIFO_CORE_MACROS_SVH
`define TAIL_DROP_PACKET_FIFO_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TDPF_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tdpf port check failed");

// Consequent must hold in the cycle after the antecedent.
`define TDPF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tdpf port check failed");

`endif

// ----- src/tdpf_pkg.sv -----
// ----------------------------------------------------------------------------
// Tail-drop packet FIFO package
// Sizes, codes and the command and status groups between control and datapath.
// ----------------------------------------------------------------------------
package tdpf_pkg;

   // Queue geometry.
   localparam int DEPTH  = 64;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);

   // Field widths.
   localparam int ID_W   = 32;
   localparam int LEN_W  = 20;
   localparam int TICK_W = 32;
   localparam int BITS_W = 32;
   localparam int OCC_W  = 7;
   localparam int KIND_W = 2;

   // Input command codes.
   localparam logic CMD_ARRIVAL = 1'b0;
   localparam logic CMD_PULL    = 1'b1;

   // Result kinds.
   localparam logic [KIND_W-1:0] KIND_NONE = 2'd0;
   localparam logic [KIND_W-1:0] KIND_DROP = 2'd1;
   localparam logic [KIND_W-1:0] KIND_SENT = 2'd2;

   // Sequencer states.
   typedef enum logic [2:0] {
      S_IDLE,
      S_EVAL,
      S_READ,
      S_SEND,
      S_FINISH
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic eval;
      logic send;
      logic finish;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic send_needed;
      logic out_free;
   } sts_type;

   // One stored descriptor.
   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [LEN_W-1:0]  len;
      logic [TICK_W-1:0] arrival;
   } slot_type;

endpackage

// ----- src/tdpf_chan_if.sv -----
// ----------------------------------------------------------------------------
// Tail-drop packet FIFO channels
// Request, response and register-write channels with valid/ready handshakes.
// ----------------------------------------------------------------------------

// Request channel: arrivals and pull requests.
interface tdpf_req_if;
   logic                             valid;
   logic                             ready;
   logic                             command;
   logic [tdpf_pkg::ID_W-1:0]        packet_id;
   logic [tdpf_pkg::LEN_W-1:0]       packet_bits;
   logic [tdpf_pkg::TICK_W-1:0]      now_ticks;

   modport source (output valid, command, packet_id, packet_bits, now_ticks,
                   input ready);
   modport sink   (input valid, command, packet_id, packet_bits, now_ticks,
                   output ready);
endinterface

// Response channel: one result item per request item.
interface tdpf_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [tdpf_pkg::KIND_W-1:0]      event_kind;
   logic [tdpf_pkg::ID_W-1:0]        out_id;
   logic [tdpf_pkg::LEN_W-1:0]       out_bits;
   logic [tdpf_pkg::TICK_W-1:0]      wait_ticks;
   logic [tdpf_pkg::OCC_W-1:0]       occupancy_before_send;
   logic [tdpf_pkg::BITS_W-1:0]      queued_bits_now;
   logic [tdpf_pkg::OCC_W-1:0]       entries_now;

   modport source (output valid, event_kind, out_id, out_bits, wait_ticks,
                   occupancy_before_send, queued_bits_now, entries_now,
                   input ready);
   modport sink   (input valid, event_kind, out_id, out_bits, wait_ticks,
                   occupancy_before_send, queued_bits_now, entries_now,
                   output ready);
endinterface

// Register-write channel for the capacity register.
interface tdpf_csr_if;
   logic                             valid;
   logic                             ready;
   logic [tdpf_pkg::BITS_W-1:0]      capacity_bits;

   modport source (output valid, capacity_bits, input ready);
   modport sink   (input valid, capacity_bits, output ready);
endinterface

// ----- src/tail_drop_packet_fifo_core.sv -----
// Each accepted item is captured and evaluated; a drop or an item that sends
// nothing then loads its result, and an item that sends a packet first reads the
// head descriptor; the result load waits while rsp is stalled. A new item is
// taken only once the last result is loaded, as set by the sequencer.
// Reset is synchronous: pointers, counts, bit total and capacity are restored;
// the descriptor memory is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// Tail-drop packet FIFO core
// Packet descriptor queue with a bit-capacity limit and a pull-driven server.
// ----------------------------------------------------------------------------
module tail_drop_packet_fifo_core (
   input  logic        clock,
   input  logic        reset,
   tdpf_req_if.sink    req_chan,
   tdpf_rsp_if.source  rsp_chan,
   tdpf_csr_if.sink    csr_chan
);

   tdpf_pkg::cmd_type cmd;
   tdpf_pkg::sts_type sts;

   // Item sequencer.
   tdpf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Queue storage and arithmetic.
   tdpf_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .sts      (sts),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

endmodule

// ----- src/tdpf_ctrl.sv -----
// ----------------------------------------------------------------------------
// Tail-drop packet FIFO controller
// Sequences each item through capture, evaluation, head read (for a send) and result load.
// ----------------------------------------------------------------------------
module tdpf_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  tdpf_pkg::sts_type sts,
   output tdpf_pkg::cmd_type cmd
);

   tdpf_pkg::state_type state_ff;
   tdpf_pkg::state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tdpf_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in    = state_ff;
      req_ready   = 1'b0;
      cmd         = '0;
      case (state_ff)
         tdpf_pkg::S_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
            if (req_valid) begin
               state_in = tdpf_pkg::S_EVAL;
            end
         end
         tdpf_pkg::S_EVAL: begin
            cmd.eval = 1'b1;
            state_in = sts.send_needed ? tdpf_pkg::S_READ : tdpf_pkg::S_FINISH;
         end
         tdpf_pkg::S_READ: begin
            // The head descriptor is read from memory during this cycle.
            state_in = tdpf_pkg::S_SEND;
         end
         tdpf_pkg::S_SEND: begin
            if (sts.out_free) begin
               cmd.send = 1'b1;
               state_in = tdpf_pkg::S_IDLE;
            end
         end
         tdpf_pkg::S_FINISH: begin
            if (sts.out_free) begin
               cmd.finish = 1'b1;
               state_in   = tdpf_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = tdpf_pkg::S_IDLE;
         end
      endcase
   end

endmodule

// ----- src/tdpf_datapath.sv -----
// ----------------------------------------------------------------------------
// Tail-drop packet FIFO datapath
// Descriptor memory, queue pointers, bit total, capacity register and the
// result register.
// ----------------------------------------------------------------------------
module tdpf_datapath (
   input  logic                     clock,
   input  logic                     reset,
   input  tdpf_pkg::cmd_type        cmd,
   output tdpf_pkg::sts_type        sts,
   tdpf_req_if.sink                 req_chan,
   tdpf_rsp_if.source               rsp_chan,
   tdpf_csr_if.sink                 csr_chan
);

   // Captured item.
   logic                           in_cmd_ff;
   logic [tdpf_pkg::ID_W-1:0]      in_id_ff;
   logic [tdpf_pkg::LEN_W-1:0]     in_bits_ff;
   logic [tdpf_pkg::TICK_W-1:0]    in_now_ff;

   // Queue state.
   logic [tdpf_pkg::ADDR_W-1:0]    head_ff, head_in;
   logic [tdpf_pkg::ADDR_W-1:0]    tail_ff, tail_in;
   logic [tdpf_pkg::CNT_W-1:0]     count_ff, count_in;
   logic [tdpf_pkg::BITS_W-1:0]    total_ff, total_in;
   logic                           waiting_ff, waiting_in;
   logic [tdpf_pkg::BITS_W-1:0]    capacity_ff;
   logic                           drop_ff;

   // Descriptor memory and its registered read port.
   tdpf_pkg::slot_type             slot_mem [tdpf_pkg::DEPTH];
   tdpf_pkg::slot_type             rd_ff;

   // Result register.
   logic                           out_valid_ff;
   logic [tdpf_pkg::KIND_W-1:0]    out_kind_ff;
   logic [tdpf_pkg::ID_W-1:0]      out_id_ff;
   logic [tdpf_pkg::LEN_W-1:0]     out_bits_ff;
   logic [tdpf_pkg::TICK_W-1:0]    out_wait_ff;
   logic [tdpf_pkg::OCC_W-1:0]     out_occ_ff;
   logic [tdpf_pkg::BITS_W-1:0]    out_queued_ff;
   logic [tdpf_pkg::OCC_W-1:0]     out_entries_ff;

   // Evaluation of the captured item.
   logic [tdpf_pkg::BITS_W:0]      sum;
   logic                           is_arrival;
   logic                           drop;
   logic                           enqueue;
   logic [tdpf_pkg::CNT_W-1:0]     count_after_eval;
   logic                           waiting_after_eval;
   logic [tdpf_pkg::BITS_W-1:0]    head_len;
   logic [tdpf_pkg::BITS_W-1:0]    total_after_send;

   assign is_arrival = (in_cmd_ff == tdpf_pkg::CMD_ARRIVAL);
   assign sum        = {1'b0, total_ff} + (tdpf_pkg::BITS_W + 1)'(in_bits_ff);
   assign drop       = is_arrival &&
                       ((sum > {1'b0, capacity_ff}) ||
                        (count_ff == tdpf_pkg::CNT_W'(tdpf_pkg::DEPTH)));
   assign enqueue    = is_arrival && !drop;
   assign count_after_eval   = count_ff + tdpf_pkg::CNT_W'(enqueue);
   assign waiting_after_eval = waiting_ff || !is_arrival;

   // A send follows whenever the server waits and a packet is queued, unless the item is dropped.
   assign sts.send_needed = !drop && waiting_after_eval && (count_after_eval != '0);
   assign sts.out_free    = !out_valid_ff || rsp_chan.ready;

   // Removing the head packet lowers the total, never below zero.
   assign head_len         = tdpf_pkg::BITS_W'(rd_ff.len);
   assign total_after_send = (total_ff >= head_len) ? (total_ff - head_len) : '0;

   // Item capture; payload needs no reset.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         in_cmd_ff  <= req_chan.command;
         in_id_ff   <= req_chan.packet_id;
         in_bits_ff <= req_chan.packet_bits;
         in_now_ff  <= req_chan.now_ticks;
      end
   end

   // Queue state updates for evaluation and send.
   always_comb begin
      head_in    = head_ff;
      tail_in    = tail_ff;
      count_in   = count_ff;
      total_in   = total_ff;
      waiting_in = waiting_ff;
      if (cmd.eval) begin
         waiting_in = waiting_after_eval;
         if (enqueue) begin
            tail_in  = (tail_ff == tdpf_pkg::ADDR_W'(tdpf_pkg::DEPTH - 1)) ?
                       '0 : tail_ff + 1'b1;
            count_in = count_after_eval;
            total_in = sum[tdpf_pkg::BITS_W-1:0];
         end
      end else if (cmd.send) begin
         head_in    = (head_ff == tdpf_pkg::ADDR_W'(tdpf_pkg::DEPTH - 1)) ?
                      '0 : head_ff + 1'b1;
         count_in   = count_ff - 1'b1;
         total_in   = total_after_send;
         waiting_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff    <= '0;
         tail_ff    <= '0;
         count_ff   <= '0;
         total_ff   <= '0;
         waiting_ff <= 1'b1;
      end else begin
         head_ff    <= head_in;
         tail_ff    <= tail_in;
         count_ff   <= count_in;
         total_ff   <= total_in;
         waiting_ff <= waiting_in;
      end
   end

   // Drop flag for the result of a non-sending item.
   always_ff @(posedge clock) begin
      if (cmd.eval) begin
         drop_ff <= drop;
      end
   end

   // Capacity register; writes are always taken.
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= '1;
      end else if (csr_chan.valid) begin
         capacity_ff <= csr_chan.capacity_bits;
      end
   end

   // Descriptor memory: written at the tail, head read every cycle.
   always_ff @(posedge clock) begin
      if (cmd.eval && enqueue) begin
         slot_mem[tail_ff] <= '{id: in_id_ff, len: in_bits_ff, arrival: in_now_ff};
      end
   end

   always_ff @(posedge clock) begin
      rd_ff <= slot_mem[head_ff];
   end

   // Result register valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.send || cmd.finish) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   // Result register payload.
   always_ff @(posedge clock) begin
      if (cmd.send) begin
         out_kind_ff    <= tdpf_pkg::KIND_SENT;
         out_id_ff      <= rd_ff.id;
         out_bits_ff    <= rd_ff.len;
         out_wait_ff    <= in_now_ff - rd_ff.arrival;
         out_occ_ff     <= tdpf_pkg::OCC_W'(count_ff);
         out_queued_ff  <= total_after_send;
         out_entries_ff <= tdpf_pkg::OCC_W'(count_ff - 1'b1);
      end else if (cmd.finish) begin
         out_kind_ff    <= drop_ff ? tdpf_pkg::KIND_DROP : tdpf_pkg::KIND_NONE;
         out_id_ff      <= drop_ff ? in_id_ff : '0;
         out_bits_ff    <= drop_ff ? in_bits_ff : '0;
         out_wait_ff    <= '0;
         out_occ_ff     <= '0;
         out_queued_ff  <= total_ff;
         out_entries_ff <= tdpf_pkg::OCC_W'(count_ff);
      end
   end

   assign rsp_chan.valid                 = out_valid_ff;
   assign rsp_chan.event_kind            = out_kind_ff;
   assign rsp_chan.out_id                = out_id_ff;
   assign rsp_chan.out_bits              = out_bits_ff;
   assign rsp_chan.wait_ticks            = out_wait_ff;
   assign rsp_chan.occupancy_before_send = out_occ_ff;
   assign rsp_chan.queued_bits_now       = out_queued_ff;
   assign rsp_chan.entries_now           = out_entries_ff;

endmodule

// ----- src/tdpf_checker.sv -----
// ----------------------------------------------------------------------------
// Tail-drop packet FIFO port checker
// Checks result items seen on the top-level ports.
// ----------------------------------------------------------------------------
`include "tail_drop_packet_fifo_core_macros.svh"

module tdpf_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [tdpf_pkg::KIND_W-1:0]       rsp_kind,
   input logic [tdpf_pkg::TICK_W-1:0]       rsp_wait,
   input logic [tdpf_pkg::OCC_W-1:0]        rsp_occ,
   input logic [tdpf_pkg::OCC_W-1:0]        rsp_entries
);

   // A stalled result item stays offered.
   `TDPF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

   // A send removes exactly one entry.
   `TDPF_ASSERT_SAME(a_send_occ, clock, reset, rsp_valid && (rsp_kind == tdpf_pkg::KIND_SENT), rsp_occ == rsp_entries + 1'b1)

   // Items that send nothing carry no wait time and no occupancy.
   `TDPF_ASSERT_SAME(a_nosend_zero, clock, reset, rsp_valid && (rsp_kind != tdpf_pkg::KIND_SENT), (rsp_wait == '0) && (rsp_occ == '0))

   // The entry count never exceeds the queue depth.
   `TDPF_ASSERT_SAME(a_entries_max, clock, reset, rsp_valid, rsp_entries <= tdpf_pkg::OCC_W'(tdpf_pkg::DEPTH))

endmodule

bind tail_drop_packet_fifo_core tdpf_checker u_tdpf_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_kind    (rsp_chan.event_kind),
   .rsp_wait    (rsp_chan.wait_ticks),
   .rsp_occ     (rsp_chan.occupancy_before_send),
   .rsp_entries (rsp_chan.entries_now)
);

// ----- verif/tb_top.sv -----
// ----------------------------------------------------------------------------
// Tail-drop packet FIFO core testbench
// Drives arrivals and pull requests into the core through bursts with random
// gaps, stalls the result channel on a changing pattern and checks every
// result item against an in-bench model of the queue, the bit total, the
// server flag and the capacity register. The capacity is rewritten between
// phases while the core is idle, covering zero, all ones and values in between.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   // One request item as driven onto the request channel.
   typedef struct packed {
      logic                         command;
      logic [tdpf_pkg::ID_W-1:0]    packet_id;
      logic [tdpf_pkg::LEN_W-1:0]   packet_bits;
      logic [tdpf_pkg::TICK_W-1:0]  now_ticks;
   } req_item_type;

   // One result item as expected on the response channel.
   typedef struct packed {
      logic [tdpf_pkg::KIND_W-1:0]  event_kind;
      logic [tdpf_pkg::ID_W-1:0]    out_id;
      logic [tdpf_pkg::LEN_W-1:0]   out_bits;
      logic [tdpf_pkg::TICK_W-1:0]  wait_ticks;
      logic [tdpf_pkg::OCC_W-1:0]   occupancy;
      logic [tdpf_pkg::BITS_W-1:0]  queued_bits;
      logic [tdpf_pkg::OCC_W-1:0]   entries;
   } fifo_result_type;

   logic clock;
   logic reset;

   tdpf_req_if req_bus ();
   tdpf_rsp_if rsp_bus ();
   tdpf_csr_if csr_bus ();

   tail_drop_packet_fifo_core u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   // Stimulus waiting for the driver and results waiting for the monitor.
   req_item_type    pending_items[$];
   fifo_result_type expected_results[$];

   // Model state of the queue.
   tdpf_pkg::slot_type          queued_pkts[$];
   logic [tdpf_pkg::BITS_W-1:0] queued_bits_total;
   logic                        server_waiting;
   logic [tdpf_pkg::BITS_W-1:0] capacity_limit;

   int          mismatch_count;
   logic [31:0] tick_now;

   // Driver and receiver pacing.
   int burst_left;
   int gap_left;
   int stall_mode;
   int stall_left;
   int stall_tick;

   // Apply one accepted item to the model and return the result it causes.
   function automatic fifo_result_type serve_packet(input req_item_type item);
      fifo_result_type res;
      logic [tdpf_pkg::BITS_W:0] sum;
      tdpf_pkg::slot_type slot;
      res = '0;
      if (item.command == tdpf_pkg::CMD_ARRIVAL) begin
         sum = {1'b0, queued_bits_total} + (tdpf_pkg::BITS_W+1)'(item.packet_bits);
         if (sum > {1'b0, capacity_limit} || queued_pkts.size() >= tdpf_pkg::DEPTH) begin
            res.event_kind = tdpf_pkg::KIND_DROP;
            res.out_id     = item.packet_id;
            res.out_bits   = item.packet_bits;
         end else begin
            slot.id      = item.packet_id;
            slot.len     = item.packet_bits;
            slot.arrival = item.now_ticks;
            queued_pkts.push_back(slot);
            queued_bits_total = sum[tdpf_pkg::BITS_W-1:0];
         end
      end else begin
         server_waiting = 1'b1;
      end
      // A waiting server takes the head packet at once, except after a drop.
      if (res.event_kind != tdpf_pkg::KIND_DROP && server_waiting &&
          queued_pkts.size() > 0) begin
         res.occupancy  = tdpf_pkg::OCC_W'(queued_pkts.size());
         slot           = queued_pkts.pop_front();
         res.event_kind = tdpf_pkg::KIND_SENT;
         res.out_id     = slot.id;
         res.out_bits   = slot.len;
         res.wait_ticks = item.now_ticks - slot.arrival;
         if (queued_bits_total >= tdpf_pkg::BITS_W'(slot.len))
            queued_bits_total = queued_bits_total - tdpf_pkg::BITS_W'(slot.len);
         else
            queued_bits_total = '0;
         server_waiting = 1'b0;
      end
      res.queued_bits = queued_bits_total;
      res.entries     = tdpf_pkg::OCC_W'(queued_pkts.size());
      return res;
   endfunction

   function automatic void check_field(input string name, input logic [31:0] exp_val,
                                       input logic [31:0] act_val);
      if (act_val !== exp_val) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_val,
                  act_val);
         mismatch_count++;
      end
   endfunction

   // Clock.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Run limit, far beyond the slowest correct run.
   initial begin
      #5_000_000;
      $display("== FAIL ==");
      $finish;
   end

   // Request driver: bursts of random length separated by random gaps.
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         burst_left = $urandom_range(1, 24);
         gap_left   = 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            expected_results.push_back(serve_packet({req_bus.command, req_bus.packet_id,
                                                     req_bus.packet_bits,
                                                     req_bus.now_ticks}));
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_bus.valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
               req_item_type item;
               item = pending_items.pop_front();
               req_bus.valid       <= 1'b1;
               req_bus.command     <= item.command;
               req_bus.packet_id   <= item.packet_id;
               req_bus.packet_bits <= item.packet_bits;
               req_bus.now_ticks   <= item.now_ticks;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 24);
                  gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
               end
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor and receiver stall pattern.
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_mode = 0;
         stall_left = 0;
         stall_tick = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_results.size() == 0) begin
               $display("%0t: result item with none expected, kind %0h id %0h", $time,
                        rsp_bus.event_kind, rsp_bus.out_id);
               mismatch_count++;
            end else begin
               fifo_result_type exp_res;
               exp_res = expected_results.pop_front();
               check_field("event_kind", 32'(exp_res.event_kind),
                           32'(rsp_bus.event_kind));
               check_field("out_id", exp_res.out_id, rsp_bus.out_id);
               check_field("out_bits", 32'(exp_res.out_bits), 32'(rsp_bus.out_bits));
               check_field("wait_ticks", exp_res.wait_ticks, rsp_bus.wait_ticks);
               check_field("occupancy_before_send", 32'(exp_res.occupancy),
                           32'(rsp_bus.occupancy_before_send));
               check_field("queued_bits_now", exp_res.queued_bits,
                           rsp_bus.queued_bits_now);
               check_field("entries_now", 32'(exp_res.entries),
                           32'(rsp_bus.entries_now));
            end
         end
         // The stall pattern is redrawn once stall_left runs out.
         if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(20, 200);
         end
         stall_left--;
         stall_tick++;
         case (stall_mode)
            0: rsp_bus.ready <= 1'b1;
            1: rsp_bus.ready <= 1'($urandom_range(0, 1));
            2: rsp_bus.ready <= (stall_tick % 4 == 0);
            default: rsp_bus.ready <= ($urandom_range(0, 9) != 0);
         endcase
      end
   end

   task automatic add_item(input logic cmd, input logic [tdpf_pkg::ID_W-1:0] id,
                           input logic [tdpf_pkg::LEN_W-1:0] len,
                           input logic [tdpf_pkg::TICK_W-1:0] now);
      req_item_type item;
      item.command     = cmd;
      item.packet_id   = id;
      item.packet_bits = len;
      item.now_ticks   = now;
      pending_items.push_back(item);
   endtask

   // Wait until every item has been accepted and every result has arrived.
   task automatic wait_drained();
      do @(negedge clock);
      while (pending_items.size() != 0 || req_bus.valid || expected_results.size() != 0);
   endtask

   // Write the capacity register; called only while the core is idle.
   task automatic write_capacity(input logic [tdpf_pkg::BITS_W-1:0] value);
      @(posedge clock);
      csr_bus.valid         <= 1'b1;
      csr_bus.capacity_bits <= value;
      do @(posedge clock);
      while (!(csr_bus.valid && csr_bus.ready));
      csr_bus.valid  <= 1'b0;
      capacity_limit = value;
   endtask

   // Mostly small packets, with zero, maximum and full-range lengths mixed in.
   function automatic logic [tdpf_pkg::LEN_W-1:0] pick_length();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2, 3: return tdpf_pkg::LEN_W'($urandom());
         default: return tdpf_pkg::LEN_W'($urandom_range(1, 2000));
      endcase
   endfunction

   // One phase: new capacity, then random arrivals and pulls.
   task automatic run_phase(input logic [tdpf_pkg::BITS_W-1:0] cap, input int pull_pct,
                            input int count);
      wait_drained();
      write_capacity(cap);
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 49) == 0)
            tick_now = $urandom();
         else
            tick_now = tick_now + $urandom_range(0, 50);
         add_item(($urandom_range(0, 99) < pull_pct) ? tdpf_pkg::CMD_PULL :
                  tdpf_pkg::CMD_ARRIVAL, $urandom(), pick_length(), tick_now);
      end
   endtask

   // Reset, directed cases, then random phases.
   initial begin
      reset                 = 1'b1;
      req_bus.valid         = 1'b0;
      req_bus.command       = tdpf_pkg::CMD_ARRIVAL;
      req_bus.packet_id     = '0;
      req_bus.packet_bits   = '0;
      req_bus.now_ticks     = '0;
      rsp_bus.ready         = 1'b0;
      csr_bus.valid         = 1'b0;
      csr_bus.capacity_bits = '0;
      mismatch_count        = 0;
      queued_bits_total     = '0;
      server_waiting        = 1'b1;
      capacity_limit        = '1;
      tick_now              = $urandom();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Reset capacity: pull on an empty queue, immediate send, wrapped wait time,
      // pull while the server already waits.
      add_item(tdpf_pkg::CMD_PULL, 32'h1234_5678, '1, 32'h0000_0010);
      add_item(tdpf_pkg::CMD_ARRIVAL, '1, '1, 32'hFFFF_FFF0);
      add_item(tdpf_pkg::CMD_ARRIVAL, '0, '0, 32'hFFFF_FFFA);
      add_item(tdpf_pkg::CMD_ARRIVAL, 32'h0000_0001, '1, 32'h0000_0000);
      add_item(tdpf_pkg::CMD_PULL, '0, '0, 32'h0000_0005);
      add_item(tdpf_pkg::CMD_PULL, '1, '1, 32'h0000_0007);
      add_item(tdpf_pkg::CMD_PULL, '0, '0, 32'h0000_0009);
      add_item(tdpf_pkg::CMD_PULL, '0, '0, 32'h0000_000A);
      add_item(tdpf_pkg::CMD_ARRIVAL, 32'hA5A5_5A5A, 20'h5_A5A5, 32'h8000_0000);

      // Zero capacity: only zero-length arrivals get in.
      wait_drained();
      write_capacity('0);
      add_item(tdpf_pkg::CMD_ARRIVAL, 32'h0000_0010, '0, 32'h8000_0001);
      add_item(tdpf_pkg::CMD_ARRIVAL, 32'h0000_0011, 20'h0_0001, 32'h8000_0002);
      add_item(tdpf_pkg::CMD_PULL, '0, '0, 32'h8000_0003);
      add_item(tdpf_pkg::CMD_ARRIVAL, 32'h0000_0012, '1, 32'h8000_0004);

      // An arrival that exactly reaches the capacity is kept.
      wait_drained();
      write_capacity(32'd2_000_000);
      add_item(tdpf_pkg::CMD_ARRIVAL, 32'h0000_0020, 20'd1_000_000, 32'h9000_0000);
      add_item(tdpf_pkg::CMD_ARRIVAL, 32'h0000_0021, 20'd1_000_000, 32'h9000_0001);
      add_item(tdpf_pkg::CMD_ARRIVAL, 32'h0000_0022, 20'd1, 32'h9000_0002);

      // Capacity lowered below the queued bits: arrivals drop until pulls drain the queue.
      wait_drained();
      write_capacity(32'd100);
      add_item(tdpf_pkg::CMD_ARRIVAL, 32'h0000_0030, 20'd50, 32'h9000_0010);
      add_item(tdpf_pkg::CMD_PULL, '0, '0, 32'h9000_0011);
      add_item(tdpf_pkg::CMD_ARRIVAL, 32'h0000_0031, '0, 32'h9000_0012);
      add_item(tdpf_pkg::CMD_PULL, '0, '0, 32'h9000_0013);
      add_item(tdpf_pkg::CMD_ARRIVAL, 32'h0000_0032, 20'd100, 32'h9000_0014);
      add_item(tdpf_pkg::CMD_ARRIVAL, 32'h0000_0033, 20'd1, 32'h9000_0015);
      add_item(tdpf_pkg::CMD_PULL, '0, '0, 32'h9000_0016);

      // Random phases; few pulls let the queue fill up to all entries in use.
      run_phase('1, 10, 100);
      run_phase('0, 40, 30);
      run_phase(32'd67_108_800, 10, 100);
      run_phase($urandom_range(2000, 200_000), 30, 100);
      run_phase(32'd1_048_575, 50, 80);
      run_phase($urandom(), 25, 100);
      run_phase(32'd5000, 50, 80);
      run_phase('1, 70, 100);
      run_phase(32'hFFFF_FFFE, 5, 100);
      run_phase($urandom_range(10_000, 3_000_000), 40, 120);
      run_phase(32'd1, 50, 60);
      run_phase('1, 20, 150);

      wait_drained();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
